>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define TQM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define TQM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tqm_pkg.sv
package tqm_pkg;

    localparam int UNIT_SHIFT_DEF = 20;
    localparam int BYTE_SHIFT     = 3;
    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [2:0] CFG_LIMIT_DAY      = 3'd0;
    localparam logic [2:0] CFG_LIMIT_WEEK     = 3'd1;
    localparam logic [2:0] CFG_LIMIT_MONTH    = 3'd2;
    localparam logic [2:0] CFG_RESET_MINUTE   = 3'd3;
    localparam logic [2:0] CFG_RESET_WEEKDAY  = 3'd4;
    localparam logic [2:0] CFG_RESET_MONTHDAY = 3'd5;
    localparam logic [2:0] CFG_SHAPING        = 3'd6;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } tqm_event_t;

    typedef struct packed {
        logic [31:0] limit_day;
        logic [31:0] limit_week;
        logic [31:0] limit_month;
        logic [10:0] reset_minute;
        logic [2:0]  reset_weekday;
        logic [4:0]  reset_monthday;
        logic        shaping_enabled;
    } tqm_cfg_t;

    typedef struct packed {
        logic [31:0] day;
        logic [31:0] week;
        logic [31:0] month;
    } tqm_totals_t;

    typedef struct packed {
        logic day_cleared;
        logic week_cleared;
        logic month_cleared;
        logic armed;
        logic active;
    } tqm_flags_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TOTAL_MAX : s[31:0];
    endfunction

endpackage

>>> rtl/tqm_accum.sv
module tqm_accum #(
    parameter int UNIT_SHIFT = tqm_pkg::UNIT_SHIFT_DEF
) (
    input  tqm_pkg::tqm_cfg_t    cfg,
    input  logic [UNIT_SHIFT-1:0] remainder,
    input  logic [31:0]           traffic_bits,
    input  tqm_pkg::tqm_totals_t totals,
    output logic [UNIT_SHIFT-1:0] remainder_next,
    output tqm_pkg::tqm_totals_t totals_next
);
    import tqm_pkg::*;

    localparam int BYTES_W = 32 - BYTE_SHIFT;
    localparam int SUM_W   = ((UNIT_SHIFT > BYTES_W) ? UNIT_SHIFT : BYTES_W) + 1;

    logic [SUM_W-1:0] sum;
    logic [31:0]      units;

    assign sum            = SUM_W'(remainder) + SUM_W'(traffic_bits[31:BYTE_SHIFT]);
    assign units          = 32'(sum >> UNIT_SHIFT);
    assign remainder_next = sum[UNIT_SHIFT-1:0];

    // A disabled counter keeps its total.
    always_comb
    begin
        totals_next = totals;
        if (|cfg.limit_day)
        begin
            totals_next.day = sat_add(totals.day, units);
        end
        if (|cfg.limit_week)
        begin
            totals_next.week = sat_add(totals.week, units);
        end
        if (|cfg.limit_month)
        begin
            totals_next.month = sat_add(totals.month, units);
        end
    end

endmodule

>>> rtl/tqm_calendar.sv
module tqm_calendar (
    input  tqm_pkg::tqm_cfg_t     cfg,
    input  logic [10:0]            minute_of_day,
    input  logic [2:0]             weekday,
    input  logic [4:0]             day_of_month,
    input  logic                   last_day_of_month,
    input  tqm_pkg::tqm_totals_t  totals,
    input  tqm_pkg::tqm_flags_t   flags,
    output tqm_pkg::tqm_totals_t  totals_next,
    output tqm_pkg::tqm_flags_t   flags_next,
    output tqm_pkg::tqm_event_t   event_code
);
    import tqm_pkg::*;

    logic armed;
    logic month_hit;
    logic over;

    assign armed = flags.armed | (|cfg.limit_day) | (|cfg.limit_week) | (|cfg.limit_month);

    // A short month clears on its last day when the configured day never comes.
    assign month_hit = (day_of_month == cfg.reset_monthday) ||
                       (last_day_of_month && (day_of_month < cfg.reset_monthday));

    always_comb
    begin
        totals_next      = totals;
        flags_next       = flags;
        flags_next.armed = armed;
        event_code       = EV_NONE;
        over             = 1'b0;
        if (armed && cfg.shaping_enabled)
        begin
            if (|cfg.limit_day)
            begin
                if (minute_of_day == cfg.reset_minute)
                begin
                    if (!flags.day_cleared)
                    begin
                        totals_next.day        = '0;
                        flags_next.day_cleared = 1'b1;
                    end
                end
                else
                begin
                    flags_next.day_cleared = 1'b0;
                end
            end
            if (|cfg.limit_week)
            begin
                if (weekday == cfg.reset_weekday)
                begin
                    if (!flags.week_cleared)
                    begin
                        totals_next.week        = '0;
                        flags_next.week_cleared = 1'b1;
                    end
                end
                else
                begin
                    flags_next.week_cleared = 1'b0;
                end
            end
            if (|cfg.limit_month)
            begin
                if (month_hit)
                begin
                    if (!flags.month_cleared)
                    begin
                        totals_next.month        = '0;
                        flags_next.month_cleared = 1'b1;
                    end
                end
                else
                begin
                    flags_next.month_cleared = 1'b0;
                end
            end

            // The compare sees the totals after this tick's clears.
            over = ((|cfg.limit_day)   && (totals_next.day   > cfg.limit_day))   ||
                   ((|cfg.limit_week)  && (totals_next.week  > cfg.limit_week))  ||
                   ((|cfg.limit_month) && (totals_next.month > cfg.limit_month));
            if (over && !flags.active)
            begin
                flags_next.active = 1'b1;
                event_code        = EV_ON;
            end
            else if (!over && flags.active)
            begin
                flags_next.active = 1'b0;
                event_code        = EV_OFF;
            end
        end
    end

endmodule

>>> rtl/traffic_quota_meter.sv
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_we               cfg_index, cfg_data
// in        in         in_valid / in_stall  opcode, traffic_bits, calendar fields
// out       out        out_valid / out_stall event_res, over_quota, totals
//
// One word is accepted per cycle while in_stall is low.
// The input register feeds combinational add, clear and compare logic into the
// result register, so a new word can enter every cycle while the output is free.
// A stalled output holds its word; the input register then fills and in_stall rises.
// Reset clears all totals, flags and handshake state and loads the register defaults.
module traffic_quota_meter #(
    parameter int UNIT_SHIFT = tqm_pkg::UNIT_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] traffic_bits,
    input  logic [10:0] minute_of_day,
    input  logic [2:0]  weekday,
    input  logic [4:0]  day_of_month,
    input  logic        last_day_of_month,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic        over_quota,
    output logic [31:0] day_total,
    output logic [31:0] week_total,
    output logic [31:0] month_total
);
    import tqm_pkg::*;

    `include "assert_macros.svh"

    tqm_cfg_t              cfg_reg;
    logic                  in_valid_reg;
    logic                  opcode_reg;
    logic [31:0]           traffic_bits_reg;
    logic [10:0]           minute_reg;
    logic [2:0]            weekday_reg;
    logic [4:0]            mday_reg;
    logic                  last_day_reg;
    logic [UNIT_SHIFT-1:0] remainder_reg;
    tqm_totals_t           totals_reg;
    tqm_flags_t            flags_reg;
    logic                  out_valid_reg;
    tqm_event_t            event_reg;
    logic                  over_reg;
    tqm_totals_t           out_totals_reg;

    logic                  out_free;
    logic                  advance;
    logic                  accept;
    logic [UNIT_SHIFT-1:0] remainder_next;
    tqm_totals_t           acc_totals;
    tqm_totals_t           cal_totals;
    tqm_flags_t            cal_flags;
    tqm_event_t            cal_event;
    tqm_totals_t           totals_next;
    tqm_flags_t            flags_next;
    tqm_event_t            event_next;
    logic                  edge_agrees;
    logic                  tick_advance;
    logic                  day_frozen;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_day       <= '0;
            cfg_reg.limit_week      <= '0;
            cfg_reg.limit_month     <= '0;
            cfg_reg.reset_minute    <= '0;
            cfg_reg.reset_weekday   <= 3'd1;
            cfg_reg.reset_monthday  <= 5'd1;
            cfg_reg.shaping_enabled <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIMIT_DAY:      cfg_reg.limit_day       <= cfg_data;
                CFG_LIMIT_WEEK:     cfg_reg.limit_week      <= cfg_data;
                CFG_LIMIT_MONTH:    cfg_reg.limit_month     <= cfg_data;
                CFG_RESET_MINUTE:   cfg_reg.reset_minute    <= cfg_data[10:0];
                CFG_RESET_WEEKDAY:  cfg_reg.reset_weekday   <= cfg_data[2:0];
                CFG_RESET_MONTHDAY: cfg_reg.reset_monthday  <= cfg_data[4:0];
                CFG_SHAPING:        cfg_reg.shaping_enabled <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept || (in_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg       <= opcode;
            traffic_bits_reg <= traffic_bits;
            minute_reg       <= minute_of_day;
            weekday_reg      <= weekday;
            mday_reg         <= day_of_month;
            last_day_reg     <= last_day_of_month;
        end
    end

    tqm_accum #(
        .UNIT_SHIFT(UNIT_SHIFT)
    ) u_accum (
        .cfg            (cfg_reg),
        .remainder      (remainder_reg),
        .traffic_bits   (traffic_bits_reg),
        .totals         (totals_reg),
        .remainder_next (remainder_next),
        .totals_next    (acc_totals)
    );

    tqm_calendar u_calendar (
        .cfg               (cfg_reg),
        .minute_of_day     (minute_reg),
        .weekday           (weekday_reg),
        .day_of_month      (mday_reg),
        .last_day_of_month (last_day_reg),
        .totals            (totals_reg),
        .flags             (flags_reg),
        .totals_next       (cal_totals),
        .flags_next        (cal_flags),
        .event_code        (cal_event)
    );

    always_comb
    begin
        if (opcode_reg == OP_TICK)
        begin
            totals_next = cal_totals;
            flags_next  = cal_flags;
            event_next  = cal_event;
        end
        else
        begin
            totals_next = acc_totals;
            flags_next  = flags_reg;
            event_next  = EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remainder_reg <= '0;
            totals_reg    <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                if (opcode_reg == OP_SAMPLE)
                begin
                    remainder_reg <= remainder_next;
                end
                totals_reg <= totals_next;
                flags_reg  <= flags_next;
            end
            out_valid_reg <= advance || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg      <= event_next;
            over_reg       <= flags_next.active;
            out_totals_reg <= totals_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign over_quota  = over_reg;
    assign day_total   = out_totals_reg.day;
    assign week_total  = out_totals_reg.week;
    assign month_total = out_totals_reg.month;

    assign edge_agrees  = (event_reg != EV_ON || over_reg) && (event_reg != EV_OFF || !over_reg);
    assign tick_advance = advance && (opcode_reg == OP_TICK);
    assign day_frozen   = (cfg_reg.limit_day == '0) && !cfg_we;

    `TQM_ASSERT_ALWAYS(a_event_matches_flag, !out_valid_reg || edge_agrees, "edge vs flag")
    `TQM_ASSERT_NEXT(a_armed_sticky, flags_reg.armed, flags_reg.armed, "armed flag dropped")
    `TQM_ASSERT_NEXT(a_active_only_on_tick, !tick_advance, $stable(flags_reg.active), "no tick")
    `TQM_ASSERT_NEXT(a_disabled_day_holds, day_frozen, $stable(totals_reg.day), "day moved")

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tqm_pkg::*;

    localparam int UNIT_SHIFT    = UNIT_SHIFT_DEF;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 250;
    localparam longint CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic        op;
        logic [31:0] bits;
        logic [10:0] minute;
        logic [2:0]  wday;
        logic [4:0]  mday;
        logic        last_day;
    } meter_word_t;

    typedef struct packed {
        tqm_event_t  ev;
        logic        over;
        logic [31:0] day;
        logic [31:0] week;
        logic [31:0] month;
    } quota_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_LIMIT_DAY;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_SAMPLE;
    logic [31:0] traffic_bits = 32'd0;
    logic [10:0] minute_of_day = 11'd0;
    logic [2:0]  weekday = 3'd0;
    logic [4:0]  day_of_month = 5'd0;
    logic        last_day_of_month = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  event_res;
    logic        over_quota;
    logic [31:0] day_total;
    logic [31:0] week_total;
    logic [31:0] month_total;

    // Mirror of the configuration registers.
    logic [31:0] lim_day, lim_week, lim_month;
    logic [10:0] clr_minute;
    logic [2:0]  clr_wday;
    logic [4:0]  clr_mday;
    logic        shaping;

    // Predicted meter state.
    logic [UNIT_SHIFT-1:0] byte_rem;
    logic [31:0] day_tot, week_tot, month_tot;
    logic        day_done, week_done, month_done;
    logic        armed, active;

    meter_word_t   word_q[$];
    quota_result_t result_q[$];

    bit          send_idles = 1'b1;
    bit          recv_idles = 1'b1;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned pushed = 0;
    int unsigned checked = 0;
    longint      cycles = 0;

    traffic_quota_meter u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .traffic_bits      (traffic_bits),
        .minute_of_day     (minute_of_day),
        .weekday           (weekday),
        .day_of_month      (day_of_month),
        .last_day_of_month (last_day_of_month),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_res         (event_res),
        .over_quota        (over_quota),
        .day_total         (day_total),
        .week_total        (week_total),
        .month_total       (month_total)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = 64'(a) + b;
        return (s > {32'd0, TOTAL_MAX}) ? TOTAL_MAX : s[31:0];
    endfunction

    function automatic quota_result_t meter_advance(input meter_word_t w);
        quota_result_t r;
        logic [63:0]   acc;
        logic [63:0]   mb;
        logic          month_hit;
        logic          over;
        r.ev = EV_NONE;
        if (w.op == OP_SAMPLE)
        begin
            acc = 64'(byte_rem);
            acc = acc + 64'(w.bits >> BYTE_SHIFT);
            mb = acc >> UNIT_SHIFT;
            byte_rem = acc[UNIT_SHIFT-1:0];
            if (lim_day != 0) day_tot = add_clamped(day_tot, mb);
            if (lim_week != 0) week_tot = add_clamped(week_tot, mb);
            if (lim_month != 0) month_tot = add_clamped(month_tot, mb);
        end
        else
        begin
            if (lim_day != 0 || lim_week != 0 || lim_month != 0)
                armed = 1'b1;
            if (armed && shaping)
            begin
                // Each total clears once on entering its reset point and
                // rearms as soon as the calendar moves past it.
                if (lim_day != 0)
                begin
                    if (w.minute == clr_minute)
                    begin
                        if (!day_done)
                        begin
                            day_tot = 32'd0;
                            day_done = 1'b1;
                        end
                    end
                    else
                        day_done = 1'b0;
                end
                if (lim_week != 0)
                begin
                    if (w.wday == clr_wday)
                    begin
                        if (!week_done)
                        begin
                            week_tot = 32'd0;
                            week_done = 1'b1;
                        end
                    end
                    else
                        week_done = 1'b0;
                end
                if (lim_month != 0)
                begin
                    month_hit = (w.mday == clr_mday) || (w.last_day && w.mday < clr_mday);
                    if (month_hit)
                    begin
                        if (!month_done)
                        begin
                            month_tot = 32'd0;
                            month_done = 1'b1;
                        end
                    end
                    else
                        month_done = 1'b0;
                end
                over = (lim_day != 0 && day_tot > lim_day) ||
                       (lim_week != 0 && week_tot > lim_week) ||
                       (lim_month != 0 && month_tot > lim_month);
                if (over && !active)
                begin
                    active = 1'b1;
                    r.ev = EV_ON;
                end
                else if (!over && active)
                begin
                    active = 1'b0;
                    r.ev = EV_OFF;
                end
            end
        end
        r.over = active;
        r.day = day_tot;
        r.week = week_tot;
        r.month = month_tot;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 50)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Sender: presents the pending words, with random gaps between them while send_idles is set.
    always @(posedge clk)
    begin : sender
        meter_word_t w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                w.op = opcode;
                w.bits = traffic_bits;
                w.minute = minute_of_day;
                w.wday = weekday;
                w.mday = day_of_month;
                w.last_day = last_day_of_month;
                result_q.push_back(meter_advance(w));
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (send_idles && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 12);
                    in_valid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    w = word_q.pop_front();
                    opcode <= w.op;
                    traffic_bits <= w.bits;
                    minute_of_day <= w.minute;
                    weekday <= w.wday;
                    day_of_month <= w.mday;
                    last_day_of_month <= w.last_day;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted result and stalls in random bursts while recv_idles is set.
    always @(posedge clk)
    begin : receiver
        quota_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 50)
                        $display("%0t: unexpected result, expected none, actual event %0d",
                                 $time, event_res);
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("event_res", 32'(want.ev), 32'(event_res));
                    check_field("over_quota", 32'(want.over), 32'(over_quota));
                    check_field("day_total", want.day, day_total);
                    check_field("week_total", want.week, week_total);
                    check_field("month_total", want.month, month_total);
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (recv_idles && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 13);
            out_stall <= (stall_left != 0);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_LIMIT_DAY:      lim_day = val;
            CFG_LIMIT_WEEK:     lim_week = val;
            CFG_LIMIT_MONTH:    lim_month = val;
            CFG_RESET_MINUTE:   clr_minute = val[10:0];
            CFG_RESET_WEEKDAY:  clr_wday = val[2:0];
            CFG_RESET_MONTHDAY: clr_mday = val[4:0];
            CFG_SHAPING:        shaping = val[0];
            default:            ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Holds off until every pushed word has come back as a result.
    task automatic drain();
        while (checked < pushed)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_sample(input logic [31:0] bits);
        meter_word_t w;
        w.op = OP_SAMPLE;
        w.bits = bits;
        w.minute = 11'($urandom_range(0, 1439));
        w.wday = 3'($urandom);
        w.mday = 5'($urandom);
        w.last_day = 1'($urandom);
        word_q.push_back(w);
        pushed++;
    endtask

    task automatic push_tick(input logic [10:0] m, input logic [2:0] wd, input logic [4:0] md,
                             input logic ld);
        meter_word_t w;
        w.op = OP_TICK;
        w.bits = $urandom;
        w.minute = m;
        w.wday = wd;
        w.mday = md;
        w.last_day = ld;
        word_q.push_back(w);
        pushed++;
    endtask

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return TOTAL_MAX;
            2, 3:    return $urandom_range(1, 400);
            4:       return $urandom_range(1, 5000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        int          n;
        logic [31:0] bits;
        logic [10:0] m;
        logic [2:0]  wd;
        logic [4:0]  md;

        lim_day = 32'd0;
        lim_week = 32'd0;
        lim_month = 32'd0;
        clr_minute = 11'd0;
        clr_wday = 3'd1;
        clr_mday = 5'd1;
        shaping = 1'b0;
        byte_rem = '0;
        day_tot = 32'd0;
        week_tot = 32'd0;
        month_tot = 32'd0;
        day_done = 1'b0;
        week_done = 1'b0;
        month_done = 1'b0;
        armed = 1'b0;
        active = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // No limit set yet: nothing is counted and the meter stays unarmed.
        push_sample(32'hFFFF_FFFF);
        push_sample(32'd0);
        push_tick(11'd0, 3'd0, 5'd0, 1'b0);
        push_tick(11'd1439, 3'd7, 5'd31, 1'b1);
        drain();

        // Armed, but shaping off, so ticks neither clear nor compare.
        write_reg(CFG_LIMIT_DAY, 32'd2);
        write_reg(CFG_LIMIT_WEEK, TOTAL_MAX);
        write_reg(CFG_LIMIT_MONTH, 32'd0);
        write_reg(CFG_RESET_MINUTE, 32'd1439);
        write_reg(CFG_RESET_WEEKDAY, 32'd7);
        write_reg(CFG_RESET_MONTHDAY, 32'd31);
        end_writes();
        push_sample(32'hFFFF_FFFF);
        push_sample(32'hFFFF_FFF8);
        push_tick(11'd100, 3'd3, 5'd10, 1'b0);
        drain();

        write_reg(CFG_SHAPING, 32'd1);
        end_writes();
        push_tick(11'd100, 3'd3, 5'd10, 1'b0);
        push_tick(11'd1439, 3'd7, 5'd31, 1'b0);
        push_tick(11'd1439, 3'd7, 5'd31, 1'b0);
        push_sample(32'h0080_0000);
        push_sample(32'h7FFF_FFFF);
        push_tick(11'd0, 3'd0, 5'd0, 1'b0);
        drain();

        // Monthly limit only; short month clears on the last day.
        write_reg(CFG_LIMIT_DAY, 32'd0);
        write_reg(CFG_LIMIT_WEEK, 32'd0);
        write_reg(CFG_LIMIT_MONTH, 32'd5);
        write_reg(CFG_RESET_MINUTE, 32'd0);
        write_reg(CFG_RESET_WEEKDAY, 32'd0);
        write_reg(CFG_RESET_MONTHDAY, 32'd20);
        end_writes();
        push_sample(32'hFFFF_FFFF);
        push_sample(32'hFFFF_FFFF);
        push_tick(11'd500, 3'd4, 5'd10, 1'b0);
        push_tick(11'd500, 3'd4, 5'd10, 1'b1);
        push_tick(11'd500, 3'd4, 5'd25, 1'b1);
        push_tick(11'd500, 3'd4, 5'd20, 1'b0);
        drain();

        // All limits off again: the meter stays armed and over_quota stays low.
        write_reg(CFG_LIMIT_MONTH, 32'd0);
        end_writes();
        push_sample($urandom);
        push_tick(11'd0, 3'd0, 5'd20, 1'b0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_reg(CFG_LIMIT_DAY, pick_limit());
            write_reg(CFG_LIMIT_WEEK, pick_limit());
            write_reg(CFG_LIMIT_MONTH, pick_limit());
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_RESET_MINUTE, 32'd0);
                1:       write_reg(CFG_RESET_MINUTE, 32'd1439);
                default: write_reg(CFG_RESET_MINUTE, $urandom_range(0, 1439));
            endcase
            write_reg(CFG_RESET_WEEKDAY, $urandom_range(0, 7));
            write_reg(CFG_RESET_MONTHDAY, $urandom_range(0, 31));
            write_reg(CFG_SHAPING, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
            end_writes();

            if (phase == RANDOM_PHASES - 1)
            begin
                send_idles = 1'b0;
                recv_idles = 1'b0;
            end
            else
            begin
                send_idles = ($urandom_range(0, 3) != 0);
                recv_idles = ($urandom_range(0, 3) != 0);
            end

            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    case ($urandom_range(0, 5))
                        0:       bits = 32'hFFFF_FFFF;
                        1, 2:    bits = $urandom;
                        default: bits = $urandom_range(0, 32'h00FF_FFFF);
                    endcase
                    push_sample(bits);
                end
                else
                begin
                    // Calendar values land on the reset points often enough
                    // that totals clear and rearm many times per phase.
                    m = ($urandom_range(0, 2) == 0) ? clr_minute : 11'($urandom_range(0, 1439));
                    wd = ($urandom_range(0, 2) == 0) ? clr_wday : 3'($urandom);
                    md = ($urandom_range(0, 2) == 0) ? clr_mday : 5'($urandom);
                    push_tick(m, wd, md, $urandom_range(0, 3) == 0);
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/tqm_pkg.sv
rtl/tqm_accum.sv
rtl/tqm_calendar.sv
rtl/traffic_quota_meter.sv
test/tb.sv
